// File: rtl/str_pkg.sv
// ----------------------------------------------------------------------------
// str_pkg
// Shared types, register indexes, reset values and saturating helpers for
// the stepper trapezoid ramp.
// ----------------------------------------------------------------------------
package str_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_START_PERIOD    = 2'd0,
      CSR_RAMP_TICKS      = 2'd1,
      CSR_PERIOD_DELTA    = 2'd2,
      CSR_PULSES_PER_UNIT = 2'd3
   } csr_index_type;

   localparam logic [15:0] START_PERIOD_RST    = 16'd5000;
   localparam logic [15:0] RAMP_TICKS_RST      = 16'd970;
   localparam logic [7:0]  PERIOD_DELTA_RST    = 8'd4;
   localparam logic [7:0]  PULSES_PER_UNIT_RST = 8'd20;

   typedef struct packed {
      logic [15:0] start_period;
      logic [15:0] ramp_ticks;
      logic [7:0]  period_delta;
      logic [7:0]  pulses_per_unit;
   } cfg_type;

   typedef struct packed {
      logic        cmd_valid;
      logic [7:0]  cmd_angle;
      logic        cmd_dir;
   } cmd_type;

   typedef struct packed {
      logic [15:0] period;
      logic [14:0] compare;
      logic        pulse_enable;
      logic        direction;
      logic        move_done;
   } rsp_type;

   function automatic logic [15:0] sat_sub(input logic [15:0] a, input logic [7:0] d);
      logic [15:0] d16;
      d16 = {8'd0, d};
      return (a > d16) ? (a - d16) : 16'd0;
   endfunction

   function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [7:0] d);
      logic [16:0] s;
      s = {1'b0, a} + {9'd0, d};
      return s[16] ? 16'hFFFF : s[15:0];
   endfunction

endpackage

// File: rtl/str_csr.sv
// ----------------------------------------------------------------------------
// str_csr
// Configuration register file: start period, ramp length, period delta and
// pulses per angle unit.
// ----------------------------------------------------------------------------
module str_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [str_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [str_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output str_pkg::cfg_type                cfg
);
   import str_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_START_PERIOD:    cfg_in.start_period    = csr_wdata;
            CSR_RAMP_TICKS:      cfg_in.ramp_ticks      = csr_wdata;
            CSR_PERIOD_DELTA:    cfg_in.period_delta    = csr_wdata[7:0];
            CSR_PULSES_PER_UNIT: cfg_in.pulses_per_unit = csr_wdata[7:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_period    <= START_PERIOD_RST;
         cfg_ff.ramp_ticks      <= RAMP_TICKS_RST;
         cfg_ff.period_delta    <= PERIOD_DELTA_RST;
         cfg_ff.pulses_per_unit <= PULSES_PER_UNIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/str_ramp.sv
// ----------------------------------------------------------------------------
// str_ramp
// Axis state and per-tick ramp update. One item is processed per cycle in
// which step is high; the result is combinational from the current state.
// ----------------------------------------------------------------------------
module str_ramp (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  str_pkg::cmd_type cmd,
   input  str_pkg::cfg_type cfg,
   output str_pkg::rsp_type rsp
);
   import str_pkg::*;

   logic [15:0] tick_ff, tick_in;
   logic        active_ff, active_in;
   logic        running_ff, running_in;
   logic [7:0]  angle_ff, angle_in;
   logic        dir_ff, dir_in;
   logic [15:0] end_ff, end_in;
   logic [15:0] accel_end_ff, accel_end_in;
   logic [15:0] decel_start_ff, decel_start_in;
   logic        accel_ff, accel_in;
   logic        decel_ff, decel_in;
   logic [15:0] period_ff, period_in;

   logic [15:0] pulses;
   logic        end_hit, accel_hit, decel_hit;
   logic        accel_cur, decel_cur;
   logic [15:0] period_base, period_mid;
   logic        enable, done;

   always_comb begin
      tick_in        = tick_ff + 16'd1;
      active_in      = active_ff | cmd.cmd_valid;
      angle_in       = cmd.cmd_valid ? cmd.cmd_angle : angle_ff;
      dir_in         = cmd.cmd_valid ? cmd.cmd_dir : dir_ff;
      running_in     = running_ff;
      end_in         = end_ff;
      accel_end_in   = accel_end_ff;
      decel_start_in = decel_start_ff;
      accel_in       = accel_ff;
      decel_in       = decel_ff;
      period_in      = period_ff;
      enable         = 1'b0;
      done           = 1'b0;

      pulses = {8'd0, angle_in} * {8'd0, cfg.pulses_per_unit};

      // At move start the tick targets are relative to this tick, so their
      // matches reduce to compares on pulses and ramp length.
      if (!running_ff) begin
         end_hit     = (pulses == 16'd0);
         accel_hit   = (cfg.ramp_ticks == 16'd0);
         decel_hit   = (pulses == cfg.ramp_ticks);
         accel_cur   = 1'b1;
         decel_cur   = 1'b0;
         period_base = cfg.start_period;
      end else begin
         end_hit     = (tick_in == end_ff);
         accel_hit   = (tick_in == accel_end_ff);
         decel_hit   = (tick_in == decel_start_ff);
         accel_cur   = accel_ff;
         decel_cur   = decel_ff;
         period_base = period_ff;
      end

      period_mid = accel_cur ? sat_sub(period_base, cfg.period_delta) : period_base;

      if (active_in) begin
         if (!running_ff) begin
            end_in         = tick_in + pulses;
            accel_end_in   = tick_in + cfg.ramp_ticks;
            decel_start_in = tick_in + pulses - cfg.ramp_ticks;
         end
         accel_in   = accel_cur & ~accel_hit;
         decel_in   = decel_cur | decel_hit;
         period_in  = decel_in ? sat_add(period_mid, cfg.period_delta) : period_mid;
         running_in = ~end_hit;
         active_in  = ~end_hit;
         enable     = ~end_hit;
         done       = end_hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff        <= 16'd0;
         active_ff      <= 1'b0;
         running_ff     <= 1'b0;
         angle_ff       <= 8'd0;
         dir_ff         <= 1'b0;
         end_ff         <= 16'd0;
         accel_end_ff   <= 16'd0;
         decel_start_ff <= 16'd0;
         accel_ff       <= 1'b1;
         decel_ff       <= 1'b0;
         period_ff      <= START_PERIOD_RST;
      end else if (step) begin
         tick_ff        <= tick_in;
         active_ff      <= active_in;
         running_ff     <= running_in;
         angle_ff       <= angle_in;
         dir_ff         <= dir_in;
         end_ff         <= end_in;
         accel_end_ff   <= accel_end_in;
         decel_start_ff <= decel_start_in;
         accel_ff       <= accel_in;
         decel_ff       <= decel_in;
         period_ff      <= period_in;
      end
   end

   always_comb begin
      rsp.period       = period_in;
      rsp.compare      = period_in[15:1];
      rsp.pulse_enable = enable;
      rsp.direction    = dir_in;
      rsp.move_done    = done;
   end

endmodule

// File: rtl/stepper_trapezoid_ramp.sv
// ----------------------------------------------------------------------------
// stepper_trapezoid_ramp
// Trapezoidal velocity ramp for one stepper axis: one item per timer tick,
// one result per item with period, half-period compare and pin controls.
//
//   channel  direction  handshake              payload
//   req_     in         req_valid / req_ready  cmd_valid, cmd_angle, cmd_dir
//   rsp_     out        rsp_valid / rsp_ready  period, compare, pulse_enable,
//                                              direction, move_done
//   csr_     in         csr_wr_en              csr_index, csr_wdata
//
// An item passes through the input register, then through the ramp update into
// the result register. A new item is taken every cycle while the result is not stalled.
// The ramp update (8x8 pulse multiply, target compares, saturating subtract and add)
// is the path between the two registers.
// A stalled result holds in the result register; the input register then
// fills and req_ready drops. Synchronous reset clears the valid flags of both stages.
// ----------------------------------------------------------------------------
module stepper_trapezoid_ramp (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_cmd_valid,
   input  logic [7:0]                      req_cmd_angle,
   input  logic                            req_cmd_dir,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [15:0]                     rsp_period,
   output logic [14:0]                     rsp_compare,
   output logic                            rsp_pulse_enable,
   output logic                            rsp_direction,
   output logic                            rsp_move_done,
   input  logic                            csr_wr_en,
   input  logic [str_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [str_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import str_pkg::*;

   cfg_type cfg;
   cmd_type cmd_ff;
   logic    in_valid_ff;
   rsp_type rsp_in, rsp_ff;
   logic    out_valid_ff;
   logic    advance;

   str_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign advance   = in_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;

   str_ramp u_ramp (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .cmd   (cmd_ff),
      .cfg   (cfg),
      .rsp   (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff.cmd_valid <= req_cmd_valid;
         cmd_ff.cmd_angle <= req_cmd_angle;
         cmd_ff.cmd_dir   <= req_cmd_dir;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_period       = rsp_ff.period;
   assign rsp_compare      = rsp_ff.compare;
   assign rsp_pulse_enable = rsp_ff.pulse_enable;
   assign rsp_direction    = rsp_ff.direction;
   assign rsp_move_done    = rsp_ff.move_done;

endmodule
